### hdl/vpbc_pkg.sv
// ----------------------------------------------------------------------------
// vpbc_pkg
// Shared types, codes and defaults for the tenant port policy engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vpbc_pkg;

    // default sizing
    localparam int VHOST_COUNT_DEF = 256;
    localparam int POOL_DEPTH_DEF  = 16384;
    localparam int INFRA_DEPTH_DEF = 64;

    // field widths
    localparam int QUOTA_W       = 15;
    localparam int PORT_W        = 16;
    localparam int VHOST_W       = 8;
    localparam int S_TDATA_W     = 32;
    localparam int M_TDATA_W     = 24;
    localparam logic [QUOTA_W-1:0] QUOTA_RESET = 15'd8;

    // request kinds
    typedef enum logic [1:0] {
        MODE_BIND    = 2'd0,
        MODE_CONNECT = 2'd1,
        MODE_PUSH    = 2'd2,
        MODE_ADD     = 2'd3
    } mode_t;

    // result codes
    typedef enum logic [3:0] {
        ST_PASS    = 4'd0,
        ST_REUSE   = 4'd1,
        ST_NEW     = 4'd2,
        ST_INFRA   = 4'd3,
        ST_OWN     = 4'd4,
        ST_QUOTA   = 4'd5,
        ST_EMPTY   = 4'd6,
        ST_FOREIGN = 4'd7,
        ST_UNOWNED = 4'd8,
        ST_STORED  = 4'd9,
        ST_FULL    = 4'd10
    } status_t;

    // source of the returned port
    typedef enum logic [1:0] {
        SEL_IN   = 2'd0,
        SEL_HASH = 2'd1,
        SEL_FIFO = 2'd2
    } port_sel_t;

    // controller states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_HRD,
        S_HCHK,
        S_BCHK,
        S_BPOP,
        S_IRD,
        S_ICHK,
        S_OCHK,
        S_EMIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic      clr_step;
        logic      load;
        logic      hash_start;
        logic      hash_rd;
        logic      hash_adv;
        logic      cnt_rd;
        logic      fifo_rd;
        logic      commit;
        logic      push;
        logic      infra_start;
        logic      infra_rd;
        logic      infra_adv;
        logic      infra_add;
        logic      owner_rd;
        logic      set_res;
        status_t   res_code;
        port_sel_t res_sel;
        logic      emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        mode_t mode;
        logic  has_tag;
        logic  loopback;
        logic  clr_done;
        logic  hash_hit;
        logic  hash_used;
        logic  quota_hit;
        logic  fifo_empty;
        logic  fifo_full;
        logic  table_full;
        logic  infra_end;
        logic  infra_hit;
        logic  infra_full;
        logic  owner_valid;
        logic  owner_same;
        logic  out_free;
    } sts_t;

    // permit flag that goes with each result code
    function automatic logic status_allow(input status_t s);
        logic a;
        unique case (s)
            ST_PASS, ST_REUSE, ST_NEW, ST_INFRA, ST_OWN, ST_STORED: a = 1'b1;
            default: a = 1'b0;
        endcase
        return a;
    endfunction

endpackage

### hdl/vpbc_ctrl.sv
// ----------------------------------------------------------------------------
// vpbc_ctrl
// Sequencer for the policy engine: clear pass, table probes and commits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vpbc_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  vpbc_pkg::sts_t  sts,
    output vpbc_pkg::cmd_t  cmd
);
    import vpbc_pkg::*;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_code = ST_PASS;
        cmd.res_sel  = SEL_IN;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (sts.mode)
                    MODE_BIND, MODE_CONNECT: begin
                        if (!sts.has_tag || (sts.mode == MODE_CONNECT && !sts.loopback)) begin
                            cmd.set_res  = 1'b1;
                            cmd.res_code = ST_PASS;
                            state_next   = S_EMIT;
                        end else begin
                            cmd.hash_start = 1'b1;
                            state_next     = S_HRD;
                        end
                    end
                    MODE_PUSH: begin
                        cmd.set_res = 1'b1;
                        if (sts.fifo_full) begin
                            cmd.res_code = ST_FULL;
                        end else begin
                            cmd.push     = 1'b1;
                            cmd.res_code = ST_STORED;
                        end
                        state_next = S_EMIT;
                    end
                    default: begin
                        cmd.infra_start = 1'b1;
                        state_next      = S_IRD;
                    end
                endcase
            end
            S_HRD: begin
                cmd.hash_rd = 1'b1;
                state_next  = S_HCHK;
            end
            S_HCHK: begin
                priority if (sts.hash_hit) begin
                    cmd.set_res  = 1'b1;
                    cmd.res_code = ST_REUSE;
                    cmd.res_sel  = SEL_HASH;
                    state_next   = S_EMIT;
                end else if (sts.hash_used) begin
                    // occupied by another key, probe the next slot
                    cmd.hash_adv = 1'b1;
                    state_next   = S_HRD;
                end else if (sts.mode == MODE_BIND) begin
                    cmd.cnt_rd = 1'b1;
                    state_next = S_BCHK;
                end else begin
                    cmd.infra_start = 1'b1;
                    state_next      = S_IRD;
                end
            end
            S_BCHK: begin
                priority if (sts.quota_hit) begin
                    cmd.set_res  = 1'b1;
                    cmd.res_code = ST_QUOTA;
                    state_next   = S_EMIT;
                end else if (sts.fifo_empty) begin
                    cmd.set_res  = 1'b1;
                    cmd.res_code = ST_EMPTY;
                    state_next   = S_EMIT;
                end else if (sts.table_full) begin
                    cmd.set_res  = 1'b1;
                    cmd.res_code = ST_FULL;
                    state_next   = S_EMIT;
                end else begin
                    cmd.fifo_rd = 1'b1;
                    state_next  = S_BPOP;
                end
            end
            S_BPOP: begin
                cmd.commit   = 1'b1;
                cmd.set_res  = 1'b1;
                cmd.res_code = ST_NEW;
                cmd.res_sel  = SEL_FIFO;
                state_next   = S_EMIT;
            end
            S_IRD: begin
                if (sts.infra_end) begin
                    if (sts.mode == MODE_CONNECT) begin
                        cmd.owner_rd = 1'b1;
                        state_next   = S_OCHK;
                    end else begin
                        cmd.set_res = 1'b1;
                        if (sts.infra_full) begin
                            cmd.res_code = ST_FULL;
                        end else begin
                            cmd.infra_add = 1'b1;
                            cmd.res_code  = ST_STORED;
                        end
                        state_next = S_EMIT;
                    end
                end else begin
                    cmd.infra_rd = 1'b1;
                    state_next   = S_ICHK;
                end
            end
            S_ICHK: begin
                if (sts.infra_hit) begin
                    cmd.set_res  = 1'b1;
                    cmd.res_code = (sts.mode == MODE_CONNECT) ? ST_INFRA : ST_STORED;
                    state_next   = S_EMIT;
                end else begin
                    cmd.infra_adv = 1'b1;
                    state_next    = S_IRD;
                end
            end
            S_OCHK: begin
                cmd.set_res = 1'b1;
                priority if (!sts.owner_valid) begin
                    cmd.res_code = ST_UNOWNED;
                end else if (sts.owner_same) begin
                    cmd.res_code = ST_OWN;
                end else begin
                    cmd.res_code = ST_FOREIGN;
                end
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### hdl/vpbc_datapath.sv
// ----------------------------------------------------------------------------
// vpbc_datapath
// Tables, free port queue, counters and the result register of the engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vpbc_datapath #(
    parameter int VHOST_COUNT = vpbc_pkg::VHOST_COUNT_DEF,
    parameter int POOL_DEPTH  = vpbc_pkg::POOL_DEPTH_DEF,
    parameter int INFRA_DEPTH = vpbc_pkg::INFRA_DEPTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [vpbc_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic [1:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [vpbc_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                               cfg_wr_en,
    input  logic [vpbc_pkg::QUOTA_W-1:0]       cfg_wr_data,
    input  vpbc_pkg::cmd_t                     cmd,
    output vpbc_pkg::sts_t                     sts
);
    import vpbc_pkg::*;

    // derived sizes
    localparam int HAW        = $clog2(POOL_DEPTH) + 1;
    localparam int HASH_DEPTH = 2 ** HAW;
    localparam int CW         = (HAW > PORT_W) ? HAW : PORT_W;
    localparam int VW         = (VHOST_COUNT > 1) ? $clog2(VHOST_COUNT) : 1;
    localparam int PAW        = $clog2(POOL_DEPTH);
    localparam int UW         = $clog2(POOL_DEPTH + 1);
    localparam int IAW        = (INFRA_DEPTH > 1) ? $clog2(INFRA_DEPTH) : 1;
    localparam int ICW        = $clog2(INFRA_DEPTH + 1);
    localparam int HEW        = 1 + VHOST_W + 2 * PORT_W;
    localparam int OEW        = 1 + VHOST_W;
    // reciprocal of the counter count, exact for every 8-bit tenant id
    localparam int VI_SH      = VHOST_W + VW;
    localparam int VI_MUL     = ((1 << VI_SH) + VHOST_COUNT - 1) / VHOST_COUNT;

    // fold the tenant and port key onto the hash index
    function automatic logic [HAW-1:0] hash_key(input logic [VHOST_W-1:0] v,
                                                input logic [PORT_W-1:0] p);
        logic [VHOST_W+PORT_W-1:0] k;
        logic [HAW-1:0]            h;
        k = {v, p};
        h = '0;
        for (int i = 0; i < VHOST_W + PORT_W; i++) begin
            h[i % HAW] = h[i % HAW] ^ k[i];
        end
        return h;
    endfunction

    // tenant id modulo the counter count by reciprocal multiplication
    function automatic logic [VW-1:0] vhost_index(input logic [VHOST_W-1:0] v);
        logic [31:0]        prod;
        logic [VHOST_W-1:0] q;
        logic [31:0]        r;
        prod = 32'(v) * 32'(VI_MUL);
        q    = VHOST_W'(prod >> VI_SH);
        r    = 32'(v) - 32'(q) * 32'(VHOST_COUNT);
        return r[VW-1:0];
    endfunction

    // request fields
    mode_t              mode_reg;
    logic               has_tag_reg;
    logic [VHOST_W-1:0] vhost_reg;
    logic [PORT_W-1:0]  port_reg;
    logic               loopback_reg;

    // control registers
    logic [QUOTA_W-1:0] quota_reg, quota_next;
    logic [CW-1:0]      clr_reg, clr_next;
    logic [HAW-1:0]     haddr_reg, haddr_next;
    logic [PAW-1:0]     head_reg, head_next;
    logic [PAW-1:0]     tail_reg, tail_next;
    logic [UW-1:0]      fill_reg, fill_next;
    logic [UW-1:0]      used_reg, used_next;
    logic [ICW-1:0]     iidx_reg, iidx_next;
    logic [ICW-1:0]     icnt_reg, icnt_next;
    logic               m_valid_reg, m_valid_next;

    // payload registers
    status_t            res_status_reg;
    logic [PORT_W-1:0]  res_port_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    // memories and their read registers
    logic [HEW-1:0]     hash_mem  [HASH_DEPTH];
    logic [OEW-1:0]     owner_mem [2 ** PORT_W];
    logic [QUOTA_W-1:0] cnt_mem   [VHOST_COUNT];
    logic [PORT_W-1:0]  fifo_mem  [POOL_DEPTH];
    logic [PORT_W-1:0]  infra_mem [INFRA_DEPTH];
    logic [HEW-1:0]     hash_rdata_reg;
    logic [OEW-1:0]     owner_rdata_reg;
    logic [QUOTA_W-1:0] cnt_rdata_reg;
    logic [PORT_W-1:0]  fifo_rdata_reg;
    logic [PORT_W-1:0]  infra_rdata_reg;

    logic [VW-1:0]      vi;
    logic               cnt_clr_hit;

    logic               hash_we;
    logic [HAW-1:0]     hash_wa;
    logic [HEW-1:0]     hash_wd;
    logic               owner_we;
    logic [PORT_W-1:0]  owner_wa;
    logic [OEW-1:0]     owner_wd;
    logic               cnt_we;
    logic [VW-1:0]      cnt_wa;
    logic [QUOTA_W-1:0] cnt_wd;

    assign vi          = vhost_index(vhost_reg);
    assign cnt_clr_hit = ({1'b0, clr_reg} < (CW + 1)'(VHOST_COUNT));

    // request capture
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg     <= mode_t'(s_tuser);
            has_tag_reg  <= s_tdata[0];
            vhost_reg    <= s_tdata[8:1];
            port_reg     <= s_tdata[24:9];
            loopback_reg <= s_tdata[25];
        end
    end

    // write port selection, clear pass first
    always_comb begin
        hash_we  = cmd.clr_step || cmd.commit;
        hash_wa  = cmd.clr_step ? clr_reg[HAW-1:0] : haddr_reg;
        hash_wd  = cmd.clr_step ? '0 : {1'b1, vhost_reg, port_reg, fifo_rdata_reg};
        owner_we = cmd.clr_step || cmd.commit;
        owner_wa = cmd.clr_step ? clr_reg[PORT_W-1:0] : fifo_rdata_reg;
        owner_wd = cmd.clr_step ? '0 : {1'b1, vhost_reg};
        cnt_we   = (cmd.clr_step && cnt_clr_hit) || cmd.commit;
        cnt_wa   = cmd.clr_step ? clr_reg[VW-1:0] : vi;
        cnt_wd   = cmd.clr_step ? '0 : cnt_rdata_reg + 1'b1;
    end

    // assignment table, hashed on tenant and virtual port
    always_ff @(posedge aclk) begin
        if (hash_we) begin
            hash_mem[hash_wa] <= hash_wd;
        end
        if (cmd.hash_rd) begin
            hash_rdata_reg <= hash_mem[haddr_reg];
        end
    end

    // owner map indexed by real port, newest owner wins
    always_ff @(posedge aclk) begin
        if (owner_we) begin
            owner_mem[owner_wa] <= owner_wd;
        end
        if (cmd.owner_rd) begin
            owner_rdata_reg <= owner_mem[port_reg];
        end
    end

    // per-tenant port counts
    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem[cnt_wa] <= cnt_wd;
        end
        if (cmd.cnt_rd) begin
            cnt_rdata_reg <= cnt_mem[vi];
        end
    end

    // free real port queue
    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            fifo_mem[tail_reg] <= port_reg;
        end
        if (cmd.fifo_rd) begin
            fifo_rdata_reg <= fifo_mem[head_reg];
        end
    end

    // infra port list, filled in order
    always_ff @(posedge aclk) begin
        if (cmd.infra_add) begin
            infra_mem[icnt_reg[IAW-1:0]] <= port_reg;
        end
        if (cmd.infra_rd) begin
            infra_rdata_reg <= infra_mem[iidx_reg[IAW-1:0]];
        end
    end

    // pointer and counter updates
    always_comb begin
        quota_next   = cfg_wr_en ? cfg_wr_data : quota_reg;
        clr_next     = cmd.clr_step ? clr_reg + 1'b1 : clr_reg;
        haddr_next   = haddr_reg;
        if (cmd.hash_start) begin
            haddr_next = hash_key(vhost_reg, port_reg);
        end else if (cmd.hash_adv) begin
            haddr_next = haddr_reg + 1'b1;
        end
        head_next = head_reg;
        fill_next = fill_reg;
        used_next = used_reg;
        tail_next = tail_reg;
        if (cmd.commit) begin
            head_next = (head_reg == PAW'(POOL_DEPTH - 1)) ? '0 : head_reg + 1'b1;
            fill_next = fill_reg - 1'b1;
            used_next = used_reg + 1'b1;
        end
        if (cmd.push) begin
            tail_next = (tail_reg == PAW'(POOL_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
            fill_next = fill_reg + 1'b1;
        end
        iidx_next = iidx_reg;
        if (cmd.infra_start) begin
            iidx_next = '0;
        end else if (cmd.infra_adv) begin
            iidx_next = iidx_reg + 1'b1;
        end
        icnt_next = cmd.infra_add ? icnt_reg + 1'b1 : icnt_reg;
        m_valid_next = m_valid_reg;
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quota_reg   <= QUOTA_RESET;
            clr_reg     <= '0;
            haddr_reg   <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            fill_reg    <= '0;
            used_reg    <= '0;
            iidx_reg    <= '0;
            icnt_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            quota_reg   <= quota_next;
            clr_reg     <= clr_next;
            haddr_reg   <= haddr_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            fill_reg    <= fill_next;
            used_reg    <= used_next;
            iidx_reg    <= iidx_next;
            icnt_reg    <= icnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result capture and output register
    always_ff @(posedge aclk) begin
        if (cmd.set_res) begin
            res_status_reg <= cmd.res_code;
            unique case (cmd.res_sel)
                SEL_HASH: res_port_reg <= hash_rdata_reg[PORT_W-1:0];
                SEL_FIFO: res_port_reg <= fifo_rdata_reg;
                default:  res_port_reg <= port_reg;
            endcase
        end
        if (cmd.emit) begin
            m_data_reg <= {3'b000, res_status_reg, res_port_reg,
                           status_allow(res_status_reg)};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // status towards the controller
    always_comb begin
        sts.mode        = mode_reg;
        sts.has_tag     = has_tag_reg;
        sts.loopback    = loopback_reg;
        sts.clr_done    = &clr_reg;
        sts.hash_used   = hash_rdata_reg[HEW-1];
        sts.hash_hit    = hash_rdata_reg[HEW-1]
                          && hash_rdata_reg[HEW-2 -: VHOST_W] == vhost_reg
                          && hash_rdata_reg[2*PORT_W-1 -: PORT_W] == port_reg;
        sts.quota_hit   = cnt_rdata_reg >= quota_reg;
        sts.fifo_empty  = fill_reg == '0;
        sts.fifo_full   = fill_reg == UW'(POOL_DEPTH);
        sts.table_full  = used_reg >= UW'(POOL_DEPTH);
        sts.infra_end   = iidx_reg >= icnt_reg;
        sts.infra_hit   = infra_rdata_reg == port_reg;
        sts.infra_full  = icnt_reg == ICW'(INFRA_DEPTH);
        sts.owner_valid = owner_rdata_reg[OEW-1];
        sts.owner_same  = owner_rdata_reg[VHOST_W-1:0] == vhost_reg;
        sts.out_free    = !m_valid_reg || m_tready;
    end

endmodule

### hdl/vhost_port_bind_connect_policy_core.sv
// ----------------------------------------------------------------------------
// vhost_port_bind_connect_policy_core
// Tenant port policy engine: bind reuse and allocation, loopback connect
// checks, free port queue and infra port list.
// ----------------------------------------------------------------------------
// Sequence: pass-through and push results are set at dispatch; bind and connect
//   probe the hash slot by slot; a bind miss checks quota and pops the free queue;
//   a connect miss walks the infra list, then the owner map; add walks the list.
// Flow: one request in flight; the next is taken once the result has been
//   registered on the output, and a result waits while the sink holds the last.
// Reset: synchronous, active low; a clearing pass then steps through every
//   address of the hash table and the owner map and clears them and the counts
//   before the first request is taken.
`timescale 1ns / 1ps

module vhost_port_bind_connect_policy_core #(
    parameter int VHOST_COUNT = vpbc_pkg::VHOST_COUNT_DEF,
    parameter int POOL_DEPTH  = vpbc_pkg::POOL_DEPTH_DEF,
    parameter int INFRA_DEPTH = vpbc_pkg::INFRA_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // tagged_req, vhost[7:0], port[15:0], loopback, zero pad
    input  logic [vpbc_pkg::S_TDATA_W-1:0] s_tdata,
    // mode[1:0]
    input  logic [1:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // allow, port_out[15:0], status[3:0], zero pad
    output logic [vpbc_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                           cfg_wr_en,
    input  logic [vpbc_pkg::QUOTA_W-1:0]   cfg_wr_data
);
    import vpbc_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequencer
    vpbc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // tables and result path
    vpbc_datapath #(
        .VHOST_COUNT (VHOST_COUNT),
        .POOL_DEPTH  (POOL_DEPTH),
        .INFRA_DEPTH (INFRA_DEPTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .sts         (sts)
    );

    // permit flag agrees with the result code
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[0] == status_allow(status_t'(m_tdata[20:17])))
        else $error("allow flag does not match status");

    // result codes stay within the defined set
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[20:17] <= 4'(ST_FULL))
        else $error("undefined status code");

    // one request in flight at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while one is in progress");

endmodule
